// ----- sv/nec_ird_pkg.sv -----
// types, constants and the window compare for the nec infrared frame decoder
// no dependencies; imported by nec_ir_frame_decoder_top and its bench
`default_nettype none

package nec_ird_pkg;

   localparam int TIME_W = 15;
   localparam int IDX_W = 6;
   localparam int HALF_BITS = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [IDX_W-1:0] FRAME_SYMBOLS = IDX_W'(34);
   localparam logic [IDX_W-1:0] COMMAND_FIRST = IDX_W'(17);
   localparam logic [IDX_W-1:0] LAST_PAYLOAD = IDX_W'(2 * HALF_BITS);

   localparam logic [TIME_W-1:0] MARGIN_RESET = TIME_W'(200);
   localparam logic [TIME_W-1:0] LEADER_MARK_RESET = TIME_W'(9000);
   localparam logic [TIME_W-1:0] LEADER_SPACE_RESET = TIME_W'(4500);
   localparam logic [TIME_W-1:0] ONE_MARK_RESET = TIME_W'(560);
   localparam logic [TIME_W-1:0] ONE_SPACE_RESET = TIME_W'(1690);
   localparam logic [TIME_W-1:0] ZERO_MARK_RESET = TIME_W'(560);
   localparam logic [TIME_W-1:0] ZERO_SPACE_RESET = TIME_W'(560);

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_SHORT       = 2'd1,
      STATUS_BAD_LEADER  = 2'd2,
      STATUS_BAD_PAYLOAD = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_MATCH_MARGIN = 3'd0,
      CSR_LEADER_MARK  = 3'd1,
      CSR_LEADER_SPACE = 3'd2,
      CSR_ONE_MARK     = 3'd3,
      CSR_ONE_SPACE    = 3'd4,
      CSR_ZERO_MARK    = 3'd5,
      CSR_ZERO_SPACE   = 3'd6
   } csr_index_type;

   // duration within target +/- margin; a margin above the target never matches
   function automatic logic in_window(input logic [TIME_W-1:0] dur,
                                      input logic [TIME_W-1:0] target,
                                      input logic [TIME_W-1:0] margin);
      logic [TIME_W:0] upper;
      logic [TIME_W-1:0] lower;
      upper = {1'b0, target} + {1'b0, margin};
      lower = target - margin;
      return (margin <= target) && (dur >= lower) && ({1'b0, dur} <= upper);
   endfunction

endpackage

`default_nettype wire

// ----- sv/nec_ir_frame_decoder_top.sv -----
// nec infrared frame decoder: symbol input register, decode logic, result register
// depends on nec_ird_pkg for constants, status codes and the window compare
`default_nettype none

// Takes one pulse symbol (mark time, space time, last-symbol flag) per cycle.
// Symbol 0 is checked against the leader windows, symbols 1 to 16 give the
// address and 17 to 32 the command, least significant bit first; later
// symbols are counted up to 34 and otherwise ignored. A symbol with
// frame_end set produces one result (status, address, command) and clears
// the frame; address and command read zero unless the status is ok. The
// block sustains one symbol per clock unless stalled; a symbol goes through
// the input register into the result register, held until taken, and the
// input stalls only while that register is full and stalled. Timing windows
// are set through the csr port and should be written only while the block is idle.
module nec_ir_frame_decoder_top
   import nec_ird_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   // symbol input
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire  [TIME_W-1:0]       req_mark_time,
   input  wire  [TIME_W-1:0]       req_space_time,
   input  wire                     req_frame_end,
   // frame result
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [15:0]             rsp_address,
   output logic [15:0]             rsp_command,
   // configuration
   input  wire                     csr_psel,
   input  wire                     csr_penable,
   input  wire                     csr_pwrite,
   input  wire  [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   // configuration registers
   logic [TIME_W-1:0] margin_ff, leader_mark_ff, leader_space_ff;
   logic [TIME_W-1:0] one_mark_ff, one_space_ff, zero_mark_ff, zero_space_ff;
   logic              csr_write;
   csr_index_type     csr_index;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [TIME_W-1:0] s1_mark_ff, s1_space_ff;
   logic              s1_end_ff;

   // frame state
   logic [IDX_W-1:0]  sym_idx_ff, sym_idx_in;
   logic              leader_fail_ff, leader_fail_in;
   logic              payload_fail_ff, payload_fail_in;
   logic [15:0]       addr_shift_ff, addr_shift_in;
   logic [15:0]       cmd_shift_ff, cmd_shift_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [15:0]       rsp_address_ff, rsp_address_in;
   logic [15:0]       rsp_command_ff, rsp_command_in;

   logic              req_accept, out_free, s1_fire;
   logic              one_hit, zero_hit, leader_hit, bit_val;
   logic [3:0]        addr_pos, cmd_pos;
   logic [IDX_W-1:0]  idx_next;
   logic              leader_fail_next, payload_fail_next;
   logic [15:0]       addr_next, cmd_next;
   status_type        status_next;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = csr_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff       <= MARGIN_RESET;
         leader_mark_ff  <= LEADER_MARK_RESET;
         leader_space_ff <= LEADER_SPACE_RESET;
         one_mark_ff     <= ONE_MARK_RESET;
         one_space_ff    <= ONE_SPACE_RESET;
         zero_mark_ff    <= ZERO_MARK_RESET;
         zero_space_ff   <= ZERO_SPACE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MATCH_MARGIN: margin_ff       <= csr_pwdata[TIME_W-1:0];
            CSR_LEADER_MARK:  leader_mark_ff  <= csr_pwdata[TIME_W-1:0];
            CSR_LEADER_SPACE: leader_space_ff <= csr_pwdata[TIME_W-1:0];
            CSR_ONE_MARK:     one_mark_ff     <= csr_pwdata[TIME_W-1:0];
            CSR_ONE_SPACE:    one_space_ff    <= csr_pwdata[TIME_W-1:0];
            CSR_ZERO_MARK:    zero_mark_ff    <= csr_pwdata[TIME_W-1:0];
            CSR_ZERO_SPACE:   zero_space_ff   <= csr_pwdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         CSR_MATCH_MARGIN: csr_prdata = CSR_DATA_W'(margin_ff);
         CSR_LEADER_MARK:  csr_prdata = CSR_DATA_W'(leader_mark_ff);
         CSR_LEADER_SPACE: csr_prdata = CSR_DATA_W'(leader_space_ff);
         CSR_ONE_MARK:     csr_prdata = CSR_DATA_W'(one_mark_ff);
         CSR_ONE_SPACE:    csr_prdata = CSR_DATA_W'(one_space_ff);
         CSR_ZERO_MARK:    csr_prdata = CSR_DATA_W'(zero_mark_ff);
         CSR_ZERO_SPACE:   csr_prdata = CSR_DATA_W'(zero_space_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mark_ff  <= req_mark_time;
         s1_space_ff <= req_space_time;
         s1_end_ff   <= req_frame_end;
      end
   end

   // ---------------- symbol decode ----------------
   always_comb begin
      leader_hit = in_window(s1_mark_ff, leader_mark_ff, margin_ff)
                && in_window(s1_space_ff, leader_space_ff, margin_ff);
      one_hit    = in_window(s1_mark_ff, one_mark_ff, margin_ff)
                && in_window(s1_space_ff, one_space_ff, margin_ff);
      zero_hit   = in_window(s1_mark_ff, zero_mark_ff, margin_ff)
                && in_window(s1_space_ff, zero_space_ff, margin_ff);
      bit_val    = one_hit;
      addr_pos   = 4'(sym_idx_ff - IDX_W'(1));
      cmd_pos    = 4'(sym_idx_ff - COMMAND_FIRST);

      leader_fail_next  = leader_fail_ff;
      payload_fail_next = payload_fail_ff;
      addr_next         = addr_shift_ff;
      cmd_next          = cmd_shift_ff;

      if (sym_idx_ff == '0) begin
         leader_fail_next = leader_fail_ff || !leader_hit;
      end else if (sym_idx_ff <= LAST_PAYLOAD) begin
         // one is tested first; neither window marks the payload bad
         payload_fail_next = payload_fail_ff || (!one_hit && !zero_hit);
         if (sym_idx_ff < COMMAND_FIRST) begin
            addr_next[addr_pos] = addr_shift_ff[addr_pos] | bit_val;
         end else begin
            cmd_next[cmd_pos] = cmd_shift_ff[cmd_pos] | bit_val;
         end
      end

      idx_next = (sym_idx_ff < FRAME_SYMBOLS) ? sym_idx_ff + IDX_W'(1) : sym_idx_ff;

      if (idx_next < FRAME_SYMBOLS) begin
         status_next = STATUS_SHORT;
      end else if (leader_fail_next) begin
         status_next = STATUS_BAD_LEADER;
      end else if (payload_fail_next) begin
         status_next = STATUS_BAD_PAYLOAD;
      end else begin
         status_next = STATUS_OK;
      end

      // frame state: advance on every item, clear on the last symbol
      sym_idx_in      = sym_idx_ff;
      leader_fail_in  = leader_fail_ff;
      payload_fail_in = payload_fail_ff;
      addr_shift_in   = addr_shift_ff;
      cmd_shift_in    = cmd_shift_ff;
      if (s1_fire) begin
         if (s1_end_ff) begin
            sym_idx_in      = '0;
            leader_fail_in  = 1'b0;
            payload_fail_in = 1'b0;
            addr_shift_in   = '0;
            cmd_shift_in    = '0;
         end else begin
            sym_idx_in      = idx_next;
            leader_fail_in  = leader_fail_next;
            payload_fail_in = payload_fail_next;
            addr_shift_in   = addr_next;
            cmd_shift_in    = cmd_next;
         end
      end

      // result register
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_address_in = rsp_address_ff;
      rsp_command_in = rsp_command_ff;
      if (s1_fire && s1_end_ff) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = status_next;
         rsp_address_in = (status_next == STATUS_OK) ? addr_next : '0;
         rsp_command_in = (status_next == STATUS_OK) ? cmd_next : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_idx_ff      <= '0;
         leader_fail_ff  <= 1'b0;
         payload_fail_ff <= 1'b0;
         addr_shift_ff   <= '0;
         cmd_shift_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         sym_idx_ff      <= sym_idx_in;
         leader_fail_ff  <= leader_fail_in;
         payload_fail_ff <= payload_fail_in;
         addr_shift_ff   <= addr_shift_in;
         cmd_shift_ff    <= cmd_shift_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_address_ff <= rsp_address_in;
      rsp_command_ff <= rsp_command_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_command = rsp_command_ff;

`ifndef SYNTH
   // symbol count saturates at a full frame
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      sym_idx_ff <= FRAME_SYMBOLS)
      else $error("symbol count beyond a full frame");

   // a failed frame reports no address or command
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STATUS_OK) |->
         (rsp_address_ff == '0) && (rsp_command_ff == '0))
      else $error("nonzero fields on a failed frame");

   // the last symbol of a frame clears the frame state
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_end_ff |=> (sym_idx_ff == '0) && !leader_fail_ff
         && !payload_fail_ff && (addr_shift_ff == '0) && (cmd_shift_ff == '0))
      else $error("frame state not cleared after last symbol");

   // frame state only moves when a symbol is processed
   a_idx_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(sym_idx_ff))
      else $error("symbol count moved without a symbol");

   // an ok result needs a full frame count before clearing
   a_ok_full: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_end_ff && (status_next == STATUS_OK) |-> idx_next == FRAME_SYMBOLS)
      else $error("ok status on a short frame");
`endif

endmodule

`default_nettype wire

// ----- bench/nec_ir_frame_decoder_top_tb.sv -----
// self-checking bench for the nec infrared frame decoder: symbol table, a back-pressure burst, then random frames
// predicts every frame result and compares it field by field; depends on nec_ird_pkg
`timescale 1ns / 1ps

module nec_ir_frame_decoder_top_tb
   import nec_ird_pkg::*;
();

   localparam int CLK_HALF = 10;
   localparam int RESET_CYCLES = 4;
   localparam int RANDOM_ITEMS = 1590;
   localparam int PHASE_ITEMS = 230;
   localparam int CALM_ITEMS = 300;
   localparam int PRESSURE_ITEMS = 12;
   localparam int HOLD_CYCLES = 120;
   localparam int SETTLE_CYCLES = 6;
   localparam int QUIET_LIMIT = 2000;
   localparam int NUM_REGS = 7;
   localparam int SPARE_INDEX = 7;   // decodes to no register
   localparam int NUM_ROWS = 30;
   localparam int TIME_TOP = (1 << TIME_W) - 1;

   localparam logic [TIME_W-1:0] LEAD_M = LEADER_MARK_RESET;
   localparam logic [TIME_W-1:0] LEAD_S = LEADER_SPACE_RESET;
   localparam logic [TIME_W-1:0] ONE_M = ONE_MARK_RESET;
   localparam logic [TIME_W-1:0] ONE_S = ONE_SPACE_RESET;
   localparam logic [TIME_W-1:0] ZERO_M = ZERO_MARK_RESET;
   localparam logic [TIME_W-1:0] ZERO_S = ZERO_SPACE_RESET;
   localparam logic [TIME_W-1:0] TIME_MAX = TIME_W'(TIME_TOP);

   typedef struct {
      status_type  status;
      logic [15:0] address;
      logic [15:0] command;
   } frame_result_type;

   typedef struct {
      logic [TIME_W-1:0] mark;
      logic [TIME_W-1:0] space;
      int                reps;
      bit                fin;
      bit                typed;
      status_type        status;
      logic [15:0]       address;
      logic [15:0]       command;
   } stim_row_type;

   typedef enum {KIND_CLEAN, KIND_SHORT, KIND_LONG, KIND_NOISE} frame_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [TIME_W-1:0]     req_mark_time = '0;
   logic [TIME_W-1:0]     req_space_time = '0;
   logic                  req_frame_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_status;
   logic [15:0]           rsp_address;
   logic [15:0]           rsp_command;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   nec_ir_frame_decoder_top u_top (.*);

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // frame results still owed by the block, oldest first
   frame_result_type expected_frames [$];
   bit               typed_armed = 1'b0;
   frame_result_type typed_value;
   frame_result_type blank_result;
   int unsigned   mismatches = 0;
   int unsigned   items_sent = 0;
   int unsigned   results_seen = 0;
   int unsigned   quiet_cycles = 0;
   bit            tx_idle_on = 1'b1;
   bit            rx_idle_on = 1'b1;
   bit            hold_request = 1'b0;

   // decoder state as the block should hold it
   logic [IDX_W-1:0]  sym_count;
   bit                leader_bad;
   bit                payload_bad;
   logic [15:0]       addr_bits;
   logic [15:0]       cmd_bits;
   logic [TIME_W-1:0] win_reg [NUM_REGS];

   function automatic void clear_frame_state();
      sym_count = '0;
      leader_bad = 1'b0;
      payload_bad = 1'b0;
      addr_bits = '0;
      cmd_bits = '0;
   endfunction

   function automatic void reset_decoder();
      win_reg[CSR_MATCH_MARGIN] = MARGIN_RESET;
      win_reg[CSR_LEADER_MARK] = LEADER_MARK_RESET;
      win_reg[CSR_LEADER_SPACE] = LEADER_SPACE_RESET;
      win_reg[CSR_ONE_MARK] = ONE_MARK_RESET;
      win_reg[CSR_ONE_SPACE] = ONE_SPACE_RESET;
      win_reg[CSR_ZERO_MARK] = ZERO_MARK_RESET;
      win_reg[CSR_ZERO_SPACE] = ZERO_SPACE_RESET;
      clear_frame_state();
   endfunction

   // a lower edge below zero means the window can never match
   function automatic bit hits_window(input logic [TIME_W-1:0] dur,
                                      input logic [TIME_W-1:0] target);
      int lo, hi;
      lo = int'(target) - int'(win_reg[CSR_MATCH_MARGIN]);
      hi = int'(target) + int'(win_reg[CSR_MATCH_MARGIN]);
      return lo >= 0 && int'(dur) >= lo && int'(dur) <= hi;
   endfunction

   function automatic bit decode_symbol(input logic [TIME_W-1:0] mark,
                                        input logic [TIME_W-1:0] space,
                                        input logic fin, output frame_result_type res);
      logic bit_val;
      res = '{STATUS_OK, 16'h0000, 16'h0000};
      if (sym_count == '0) begin
         if (!hits_window(mark, win_reg[CSR_LEADER_MARK]) ||
             !hits_window(space, win_reg[CSR_LEADER_SPACE]))
            leader_bad = 1'b1;
      end else if (sym_count <= LAST_PAYLOAD) begin
         // a one is tried before a zero
         if (hits_window(mark, win_reg[CSR_ONE_MARK]) &&
             hits_window(space, win_reg[CSR_ONE_SPACE])) begin
            bit_val = 1'b1;
         end else if (hits_window(mark, win_reg[CSR_ZERO_MARK]) &&
                      hits_window(space, win_reg[CSR_ZERO_SPACE])) begin
            bit_val = 1'b0;
         end else begin
            bit_val = 1'b0;
            payload_bad = 1'b1;
         end
         if (sym_count < COMMAND_FIRST)
            addr_bits[int'(sym_count) - 1] = bit_val;
         else
            cmd_bits[int'(sym_count) - int'(COMMAND_FIRST)] = bit_val;
      end
      if (sym_count < FRAME_SYMBOLS)
         sym_count = sym_count + 1'b1;
      if (!fin)
         return 1'b0;
      if (sym_count < FRAME_SYMBOLS) begin
         res.status = STATUS_SHORT;
      end else if (leader_bad) begin
         res.status = STATUS_BAD_LEADER;
      end else if (payload_bad) begin
         res.status = STATUS_BAD_PAYLOAD;
      end else begin
         res.address = addr_bits;
         res.command = cmd_bits;
      end
      clear_frame_state();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("%0t ns: result %0d mismatch: %s", $time, results_seen, msg);
   endtask

   always @(posedge clock) begin : watch_ports
      frame_result_type got;
      frame_result_type want;
      bit produced;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            produced = decode_symbol(req_mark_time, req_space_time, req_frame_end, got);
            if (produced)
               expected_frames.push_back(typed_armed ? typed_value : got);
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_frames.size() == 0) begin
               report_mismatch($sformatf("none pending, got status %0d address %h command %h",
                                         rsp_status, rsp_address, rsp_command));
            end else begin
               want = expected_frames.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_address !== want.address)
                  report_mismatch($sformatf("address %h, expected %h",
                                            rsp_address, want.address));
               if (rsp_command !== want.command)
                  report_mismatch($sformatf("command %h, expected %h",
                                            rsp_command, want.command));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("FAIL nec_ir_frame_decoder_top");
      $finish;
   end

   // result side back-pressure: random bursts, plus one long hold on request
   initial begin : drive_stall
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [TIME_W-1:0] rand_time();
      return TIME_W'($urandom_range(0, TIME_TOP));
   endfunction

   // duration inside the target window, now and then on or just past an edge; any duration if the window cannot match
   function automatic logic [TIME_W-1:0] near_target(input logic [TIME_W-1:0] target);
      int lo, hi;
      int unsigned pick;
      lo = int'(target) - int'(win_reg[CSR_MATCH_MARGIN]);
      hi = int'(target) + int'(win_reg[CSR_MATCH_MARGIN]);
      if (hi > TIME_TOP)
         hi = TIME_TOP;
      if (lo < 0)
         return rand_time();
      pick = $urandom_range(0, 399);
      if (pick == 0)
         return TIME_W'(lo > 0 ? lo - 1 : lo);
      if (pick == 1)
         return TIME_W'(hi < TIME_TOP ? hi + 1 : hi);
      if (pick < 40)
         return TIME_W'(lo);
      if (pick < 80)
         return TIME_W'(hi);
      return TIME_W'($urandom_range(lo, hi));
   endfunction

   task automatic send_symbol(input logic [TIME_W-1:0] mark, input logic [TIME_W-1:0] space,
                              input logic fin, input bit use_typed,
                              input frame_result_type typed_res);
      int unsigned gap;
      @(negedge clock);
      if (tx_idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mark_time <= mark;
      req_space_time <= space;
      req_frame_end <= fin;
      typed_armed <= use_typed;
      typed_value <= typed_res;
      do @(posedge clock); while (!(req_valid && !req_stall));
      items_sent++;
   endtask

   // drops valid, waits for every owed result, then lets the pipeline drain
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_frames.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input int idx, input logic [CSR_DATA_W-1:0] data,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= CSR_ADDR_W'(4 * idx);
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // upper data bits carry junk; the register keeps only its low 15
   task automatic set_register(input int idx, input logic [TIME_W-1:0] value);
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b1, idx, {(CSR_DATA_W - TIME_W)'($urandom), value}, rdata);
      if (idx < NUM_REGS) begin
         win_reg[idx] = value;
         csr_access(1'b0, idx, '0, rdata);
         if (rdata[TIME_W-1:0] !== win_reg[idx])
            report_mismatch($sformatf("register %0d reads %h, expected %h",
                                      idx, rdata[TIME_W-1:0], win_reg[idx]));
      end
   endtask

   task automatic apply_config(input logic [TIME_W-1:0] margin,
                               input logic [TIME_W-1:0] lead_mark,
                               input logic [TIME_W-1:0] lead_space,
                               input logic [TIME_W-1:0] one_mark,
                               input logic [TIME_W-1:0] one_space,
                               input logic [TIME_W-1:0] zero_mark,
                               input logic [TIME_W-1:0] zero_space);
      set_register(CSR_MATCH_MARGIN, margin);
      set_register(CSR_LEADER_MARK, lead_mark);
      set_register(CSR_LEADER_SPACE, lead_space);
      set_register(CSR_ONE_MARK, one_mark);
      set_register(CSR_ONE_SPACE, one_space);
      set_register(CSR_ZERO_MARK, zero_mark);
      set_register(CSR_ZERO_SPACE, zero_space);
      set_register(SPARE_INDEX, rand_time());
   endtask

   task automatic configure_phase(input int phase);
      logic [TIME_W-1:0] m;
      m = TIME_W'($urandom_range(0, 300));
      case (phase)
         0: apply_config('0, LEAD_M, LEAD_S, ONE_M, ONE_S, ZERO_M, ZERO_S);
         // margin above every target: nothing can match
         1: apply_config(TIME_MAX, LEAD_M, LEAD_S, ONE_M, ONE_S, ZERO_M, ZERO_S);
         2: apply_config(m, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX);
         3: apply_config('0, '0, '0, '0, '0, '0, '0);
         // margin equal to the target reaches from zero past the top
         4: apply_config(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX,
                         TIME_MAX);
         default: begin
            if ($urandom_range(0, 1))
               apply_config(TIME_W'($urandom_range(0, 600)), LEAD_M, LEAD_S, ONE_M, ONE_S,
                            ZERO_M, ZERO_S);
            else
               apply_config(TIME_W'($urandom_range(0, 2000)), rand_time(), rand_time(),
                            rand_time(), rand_time(), rand_time(), rand_time());
         end
      endcase
   endtask

   task automatic send_frame(input frame_kind_type kind);
      int len, k;
      logic [TIME_W-1:0] mark, space;
      case (kind)
         KIND_SHORT: len = $urandom_range(1, int'(FRAME_SYMBOLS) - 1);
         KIND_LONG:  len = int'(FRAME_SYMBOLS) + $urandom_range(1, 8);
         KIND_NOISE: len = $urandom_range(1, 40);
         default:    len = int'(FRAME_SYMBOLS);
      endcase
      for (k = 0; k < len; k++) begin
         if (kind == KIND_NOISE || (k == 0 && $urandom_range(0, 19) == 0)) begin
            mark = rand_time();
            space = rand_time();
         end else if (k == 0) begin
            mark = near_target(win_reg[CSR_LEADER_MARK]);
            space = near_target(win_reg[CSR_LEADER_SPACE]);
         end else if (k <= int'(LAST_PAYLOAD)) begin
            if ($urandom_range(0, 1)) begin
               mark = near_target(win_reg[CSR_ONE_MARK]);
               space = near_target(win_reg[CSR_ONE_SPACE]);
            end else begin
               mark = near_target(win_reg[CSR_ZERO_MARK]);
               space = near_target(win_reg[CSR_ZERO_SPACE]);
            end
         end else begin
            // stop bit and trailing symbols are not checked
            mark = near_target(win_reg[CSR_ONE_MARK]);
            space = rand_time();
         end
         if (kind != KIND_NOISE && $urandom_range(0, 199) == 0)
            mark = rand_time();
         send_symbol(mark, space, k == len - 1, 1'b0, blank_result);
      end
   endtask

   initial begin : run
      int r, k, phase, random_start, phase_start;
      int unsigned roll;
      bit closes;
      frame_result_type want;
      frame_kind_type kind;
      stim_row_type directed_rows [NUM_ROWS];

      blank_result = '{STATUS_OK, 16'h0000, 16'h0000};
      typed_value = blank_result;
      reset_decoder();
      directed_rows = '{
         // lone symbols close a frame far too early
         '{LEAD_M, LEAD_S, 1, 1, 1, STATUS_SHORT, 16'h0000, 16'h0000},
         '{'0, '0, 1, 1, 1, STATUS_SHORT, 16'h0000, 16'h0000},
         '{TIME_MAX, TIME_MAX, 1, 1, 1, STATUS_SHORT, 16'h0000, 16'h0000},
         // address all ones, command all zeros
         '{LEAD_M, LEAD_S, 1, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{ONE_M, ONE_S, 16, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{ZERO_M, ZERO_S, 16, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{ONE_M, ONE_S, 1, 1, 1, STATUS_OK, 16'hffff, 16'h0000},
         // and the other way round
         '{LEAD_M, LEAD_S, 1, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{ZERO_M, ZERO_S, 16, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{ONE_M, ONE_S, 16, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{ZERO_M, ZERO_S, 1, 1, 1, STATUS_OK, 16'h0000, 16'hffff},
         // bad leader outranks a clean payload
         '{'0, '0, 1, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{ONE_M, ONE_S, 32, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{ONE_M, ONE_S, 1, 1, 1, STATUS_BAD_LEADER, 16'h0000, 16'h0000},
         // one payload symbol that is neither bit, later ones still decode
         '{LEAD_M, LEAD_S, 1, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{ONE_M, ONE_S, 5, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{15'd3000, 15'd3000, 1, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{ONE_M, ONE_S, 26, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{ONE_M, ONE_S, 1, 1, 1, STATUS_BAD_PAYLOAD, 16'h0000, 16'h0000},
         // long frame: extra symbols are ignored
         '{LEAD_M, LEAD_S, 1, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{ONE_M, ONE_S, 32, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{ONE_M, ONE_S, 10, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{ZERO_M, ZERO_S, 1, 1, 1, STATUS_OK, 16'hffff, 16'hffff},
         // durations on and just past the window edges
         '{15'd8800, 15'd4700, 1, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{15'd760, 15'd1490, 16, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{15'd359, 15'd560, 1, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{15'd360, 15'd760, 15, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{ZERO_M, ZERO_S, 1, 1, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{15'd9201, LEAD_S, 1, 0, 0, STATUS_OK, 16'h0000, 16'h0000},
         '{ONE_M, ONE_S, 33, 1, 0, STATUS_OK, 16'h0000, 16'h0000}
      };

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < NUM_ROWS; r++) begin
         for (k = 0; k < directed_rows[r].reps; k++) begin
            closes = directed_rows[r].fin && (k == directed_rows[r].reps - 1);
            want = '{directed_rows[r].status, directed_rows[r].address,
                     directed_rows[r].command};
            send_symbol(directed_rows[r].mark, directed_rows[r].space, closes,
                        closes && directed_rows[r].typed, want);
         end
      end

      // receiver holds off while lone symbols keep coming, so the input backs up
      settle_block();
      tx_idle_on = 1'b0;
      hold_request = 1'b1;
      repeat (PRESSURE_ITEMS) send_symbol(rand_time(), rand_time(), 1'b1, 1'b0, blank_result);
      while (hold_request)
         @(negedge clock);

      random_start = items_sent;
      phase = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         settle_block();
         if (items_sent - random_start >= RANDOM_ITEMS - CALM_ITEMS) begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
         end else begin
            rx_idle_on = $urandom_range(0, 3) != 0;
         end
         configure_phase(phase);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS &&
                items_sent - random_start < RANDOM_ITEMS) begin
            if (items_sent - random_start < RANDOM_ITEMS - CALM_ITEMS)
               tx_idle_on = $urandom_range(0, 3) != 0;
            else
               tx_idle_on = 1'b0;
            roll = $urandom_range(0, 19);
            if (roll < 14)
               kind = KIND_CLEAN;
            else if (roll < 16)
               kind = KIND_SHORT;
            else if (roll < 18)
               kind = KIND_LONG;
            else
               kind = KIND_NOISE;
            send_frame(kind);
         end
         phase++;
      end

      settle_block();
      if (mismatches == 0)
         $display("PASS nec_ir_frame_decoder_top");
      else
         $display("FAIL nec_ir_frame_decoder_top");
      $finish;
   end

endmodule
